>>> src/msba_pkg.sv
package msba_pkg;

   localparam int SAMPLE_W  = 12;
   localparam int POS_W     = 3;
   localparam int POS_SLOTS = 2 ** POS_W;

   localparam int SAMPLES_PER_CHANNEL_DEF = 16;
   localparam int CHANNEL_COUNT_DEF       = 8;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic [POS_W-1:0]    pos;
      logic                block_end;
   } queue_word_type;

   typedef enum logic {
      ST_ACCUM,
      ST_EMIT
   } back_state_type;

endpackage

>>> src/msba_front.sv
module msba_front import msba_pkg::*; #(
   parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                q_valid,
   input  logic                q_ready,
   output queue_word_type      q_word
);

   localparam int ROUND_W = (SAMPLES_PER_CHANNEL > 1) ? $clog2(SAMPLES_PER_CHANNEL) : 1;

   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [ROUND_W-1:0] rounds_ff, rounds_in;
   logic               last_pos;
   logic               last_round;
   logic               accept;

   assign accept     = req_valid && q_ready;
   assign req_ready  = q_ready;
   assign last_pos   = (pos_ff == POS_W'(CHANNEL_COUNT - 1));
   assign last_round = (rounds_ff == ROUND_W'(SAMPLES_PER_CHANNEL - 1));

   assign q_valid          = req_valid;
   assign q_word.sample    = req_sample;
   assign q_word.pos       = pos_ff;
   assign q_word.block_end = last_pos && last_round;

   always_comb begin
      pos_in    = pos_ff;
      rounds_in = rounds_ff;
      if (accept) begin
         if (last_pos) begin
            pos_in    = '0;
            rounds_in = last_round ? '0 : rounds_ff + ROUND_W'(1);
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         rounds_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         rounds_ff <= rounds_in;
      end
   end

   // a block ends only on the last scan position
   a_block_end_pos: assert property (@(posedge clock) disable iff (reset)
      q_word.block_end |-> q_word.pos == POS_W'(CHANNEL_COUNT - 1))
      else $error("block end off the last scan position");

endmodule

>>> src/msba_fifo.sv
module msba_fifo import msba_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  queue_word_type in_word,
   output logic           out_valid,
   input  logic           out_ready,
   output queue_word_type out_word
);

   queue_word_type mem_ff [2];
   logic           wr_ptr_ff;
   logic           rd_ptr_ff;
   logic [1:0]     count_ff;
   logic           push;
   logic           pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count overflow");

endmodule

>>> src/msba_back.sv
module msba_back import msba_pkg::*; #(
   parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   output logic                q_ready,
   input  queue_word_type      q_word,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_channel_index,
   output logic [SAMPLE_W-1:0] rsp_average,
   output logic                rsp_last
);

   localparam int ACC_W  = SAMPLE_W + $clog2(SAMPLES_PER_CHANNEL);
   localparam int SHIFT  = ACC_W + $clog2(SAMPLES_PER_CHANNEL);
   localparam int PROD_W = 2 * ACC_W + 1;
   localparam logic [63:0] RECIP_WIDE =
      ((64'd1 << SHIFT) + 64'(SAMPLES_PER_CHANNEL) - 64'd1) / 64'(SAMPLES_PER_CHANNEL);
   localparam logic [ACC_W:0] RECIP = RECIP_WIDE[ACC_W:0];

   back_state_type      state_ff, state_in;
   logic [ACC_W-1:0]    sums_ff [POS_SLOTS];
   logic [POS_W-1:0]    idx_ff;
   logic                rsp_valid_ff;
   logic [POS_W-1:0]    rsp_channel_ff;
   logic [SAMPLE_W-1:0] rsp_average_ff;
   logic                rsp_last_ff;
   logic                load;
   logic                pop;
   logic                idx_last;
   logic [PROD_W-1:0]   prod;

   assign idx_last = (idx_ff == POS_W'(CHANNEL_COUNT - 1));
   assign pop      = q_valid && q_ready;
   assign prod     = PROD_W'(sums_ff[idx_ff]) * PROD_W'(RECIP);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (pop && q_word.block_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load && idx_last) begin
               state_in = ST_ACCUM;
            end
         end
      endcase
   end

   always_comb begin
      q_ready = 1'b0;
      load    = 1'b0;
      unique case (state_ff)
         ST_ACCUM: q_ready = 1'b1;
         ST_EMIT:  load    = !rsp_valid_ff || rsp_ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < POS_SLOTS; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (pop) begin
            sums_ff[q_word.pos] <= sums_ff[q_word.pos] + ACC_W'(q_word.sample);
         end
         if (load) begin
            sums_ff[idx_ff] <= '0;
            idx_ff          <= idx_last ? '0 : idx_ff + POS_W'(1);
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_channel_ff <= idx_ff;
         rsp_average_ff <= prod[SHIFT +: SAMPLE_W];
         rsp_last_ff    <= idx_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_channel_ff;
   assign rsp_average       = rsp_average_ff;
   assign rsp_last          = rsp_last_ff;

   a_no_pop_in_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> !pop)
      else $error("queue popped during result burst");

   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_channel_ff == POS_W'(CHANNEL_COUNT - 1))
      else $error("last flag on wrong channel");

   a_burst_done: assert property (@(posedge clock) disable iff (reset)
      load && idx_last |=> state_ff == ST_ACCUM && idx_ff == '0)
      else $error("burst did not return to accumulate");

endmodule

>>> src/multichannel_scan_block_averager_top.sv
// one sample word per cycle is taken while the two-word queue has room
// the sum for a sample is updated when its word is popped from the queue by the accumulator
// a block end starts a burst of CHANNEL_COUNT results, one per cycle from the output register while rsp_ready is high
// first result is valid once the block-end word has left the queue and the output register is loaded
// the burst holds the accumulator, so input stalls once the queue fills during it
// synchronous active-high reset clears position, round count, sums, queue and output valid
module multichannel_scan_block_averager_top import msba_pkg::*; #(
   parameter int SAMPLES_PER_CHANNEL = SAMPLES_PER_CHANNEL_DEF,
   parameter int CHANNEL_COUNT       = CHANNEL_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [POS_W-1:0]    rsp_channel_index,
   output logic [SAMPLE_W-1:0] rsp_average,
   output logic                rsp_last
);

   logic           front_valid;
   logic           front_ready;
   queue_word_type front_word;
   logic           back_valid;
   logic           back_ready;
   queue_word_type back_word;

   msba_front #(
      .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
      .CHANNEL_COUNT       (CHANNEL_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .q_valid    (front_valid),
      .q_ready    (front_ready),
      .q_word     (front_word)
   );

   msba_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_word   (front_word),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_word  (back_word)
   );

   msba_back #(
      .SAMPLES_PER_CHANNEL (SAMPLES_PER_CHANNEL),
      .CHANNEL_COUNT       (CHANNEL_COUNT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (back_valid),
      .q_ready           (back_ready),
      .q_word            (back_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_average       (rsp_average),
      .rsp_last          (rsp_last)
   );

endmodule
